/* sv/mrs_pkg.sv */
// shared types, codes and the crc helper for the modbus register server
package mrs_pkg;

  localparam int MAP_DEPTH_DEF      = 256;
  localparam int FRAME_DEPTH_DEF    = 256;
  localparam int MAX_READ_WORDS_DEF = 17;

  localparam int FIDX_W = 9;

  localparam logic [1:0] CMD_RX   = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic KIND_RESP  = 1'b0;
  localparam logic KIND_LOCAL = 1'b1;

  localparam logic [7:0] F_RD_COILS = 8'h01;
  localparam logic [7:0] F_RD_DISC  = 8'h02;
  localparam logic [7:0] F_RD_HOLD  = 8'h03;
  localparam logic [7:0] F_RD_INPUT = 8'h04;
  localparam logic [7:0] F_WR_COIL  = 8'h05;
  localparam logic [7:0] F_WR_REG   = 8'h06;
  localparam logic [7:0] F_WR_MULTI = 8'h10;
  localparam logic [7:0] F_EXC_FLAG = 8'h80;

  localparam logic [2:0] FK_NONE  = 3'd0;
  localparam logic [2:0] FK_READ  = 3'd1;
  localparam logic [2:0] FK_ECHO  = 3'd2;
  localparam logic [2:0] FK_MULTI = 3'd3;
  localparam logic [2:0] FK_OTHER = 3'd4;

  localparam logic [3:0] SEL_ID   = 4'd0;
  localparam logic [3:0] SEL_FUNC = 4'd1;
  localparam logic [3:0] SEL_CNT  = 4'd2;
  localparam logic [3:0] SEL_WHI  = 4'd3;
  localparam logic [3:0] SEL_WLO  = 4'd4;
  localparam logic [3:0] SEL_AHI  = 4'd5;
  localparam logic [3:0] SEL_ALO  = 4'd6;
  localparam logic [3:0] SEL_VHI  = 4'd7;
  localparam logic [3:0] SEL_VLO  = 4'd8;
  localparam logic [3:0] SEL_CLO  = 4'd9;
  localparam logic [3:0] SEL_CHI  = 4'd10;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic [15:0] reg_address;
    logic [15:0] reg_value;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] read_value;
  } out_word_t;

  typedef struct packed {
    logic       clr;
    logic       take;
    logic       lrd_out;
    logic       judge;
    logic       fr_rd_hi;
    logic       fr_rd_lo;
    logic       wr_word;
    logic       map_rd;
    logic       emit;
    logic [3:0] sel;
    logic       i_inc;
    logic       i_clr;
  } ctl_t;

  typedef struct packed {
    logic       clr_done;
    logic       out_free;
    logic       good;
    logic [2:0] fk;
    logic       q_zero;
    logic       i_last;
  } sts_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int n = 0; n < 8; n++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 16'hA001;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* sv/mrs_dp.sv */
// datapath: frame store, register maps, crc, response byte mux and output register
module mrs_dp #(
  parameter int MAP_DEPTH      = mrs_pkg::MAP_DEPTH_DEF,
  parameter int FRAME_DEPTH    = mrs_pkg::FRAME_DEPTH_DEF,
  parameter int MAX_READ_WORDS = mrs_pkg::MAX_READ_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mrs_pkg::in_word_t  in_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  mrs_pkg::ctl_t      ctl,
  output mrs_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_ready,
  output mrs_pkg::out_word_t out_data
);
  import mrs_pkg::*;

  localparam int AW  = $clog2(MAP_DEPTH);
  localparam int FAW = $clog2(FRAME_DEPTH);
  localparam int LW  = $clog2(FRAME_DEPTH + 2);
  localparam int QW  = $clog2(MAX_READ_WORDS + 1);

  logic [15:0] hold_mem [MAP_DEPTH];
  logic [15:0] inp_mem  [MAP_DEPTH];
  logic [7:0]  frame_mem [FRAME_DEPTH];

  logic [7:0]    slave_id_r;
  logic [LW-1:0] frame_len_r, resp_len_r;
  logic [15:0]   crc_r, rcrc_r;
  logic [7:0]    hdr_r [6];
  logic [7:0]    func_r, hi_r, fr_q_r;
  logic [2:0]    fk_r;
  logic [15:0]   addr_r, raw_r, h_q_r, i_q_r;
  logic [QW-1:0] q_r, i_r;
  logic [AW-1:0] clr_cnt_r;
  logic          out_valid_r, map_ok_r, fr_ok_r, hsel_r;
  out_word_t     out_r;

  logic [7:0]        hm [6];
  logic [7:0]        func_c, tx_b;
  logic [15:0]       addr_c, raw_c, word_v, val_v;
  logic [QW-1:0]     q_c;
  logic [2:0]        fk_c;
  logic              good_c, is_rx, is_load, is_read, out_free;
  logic [16:0]       msum;
  logic              m_in, ra_in, a6_in;
  logic [FIDX_W-1:0] fidx;
  logic              fr_in, fr_re;
  logic              h_we, h_re, i_we;
  logic [AW-1:0]     h_wa, h_ra, i_wa;
  logic [15:0]       h_wd, i_wd;

  assign is_rx   = ctl.take && (in_data.command == CMD_RX);
  assign is_load = ctl.take && (in_data.command == CMD_LOAD);
  assign is_read = ctl.take && (in_data.command == CMD_READ);

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      hm[k] = (LW'(k) < frame_len_r) ? hdr_r[k] : 8'h00;
    end
  end

  assign func_c = hm[1];
  assign addr_c = {hm[2], hm[3]};
  assign raw_c  = {hm[4], hm[5]};
  assign q_c    = (raw_c < 16'(MAX_READ_WORDS)) ? raw_c[QW-1:0] : QW'(MAX_READ_WORDS);

  always_comb begin
    if (func_c inside {F_RD_COILS, F_RD_DISC, F_WR_COIL}) begin
      fk_c = FK_NONE;
    end else if (func_c inside {F_RD_HOLD, F_RD_INPUT}) begin
      fk_c = FK_READ;
    end else if (func_c == F_WR_REG) begin
      fk_c = FK_ECHO;
    end else if (func_c == F_WR_MULTI) begin
      fk_c = FK_MULTI;
    end else begin
      fk_c = FK_OTHER;
    end
  end

  assign good_c = (frame_len_r >= LW'(4)) && (frame_len_r <= LW'(FRAME_DEPTH)) &&
                  (crc_r == 16'h0000) && (hm[0] == slave_id_r);

  assign msum  = {1'b0, addr_r} + 17'(i_r);
  assign m_in  = msum < 17'(MAP_DEPTH);
  assign ra_in = {1'b0, in_data.reg_address} < 17'(MAP_DEPTH);
  assign a6_in = {1'b0, addr_c} < 17'(MAP_DEPTH);

  assign fidx  = FIDX_W'(7) + FIDX_W'({i_r, 1'b0}) + (ctl.fr_rd_lo ? FIDX_W'(1) : FIDX_W'(0));
  assign fr_in = fidx < FIDX_W'(resp_len_r);
  assign fr_re = ctl.fr_rd_hi || ctl.fr_rd_lo;

  // holding map port
  always_comb begin
    h_we = 1'b0;
    h_wa = clr_cnt_r;
    h_wd = 16'h0000;
    if (ctl.clr) begin
      h_we = 1'b1;
    end else if (ctl.judge && good_c && (fk_c == FK_ECHO) && a6_in) begin
      h_we = 1'b1;
      h_wa = addr_c[AW-1:0];
      h_wd = raw_c;
    end else if (ctl.wr_word && m_in) begin
      h_we = 1'b1;
      h_wa = msum[AW-1:0];
      h_wd = {hi_r, fr_ok_r ? fr_q_r : 8'h00};
    end
  end

  assign h_re = ctl.map_rd || is_read;
  assign h_ra = ctl.map_rd ? msum[AW-1:0] : in_data.reg_address[AW-1:0];

  assign i_we = ctl.clr || (is_load && ra_in);
  assign i_wa = ctl.clr ? clr_cnt_r : in_data.reg_address[AW-1:0];
  assign i_wd = ctl.clr ? 16'h0000 : in_data.reg_value;

  always_ff @(posedge clk) begin
    if (h_we) begin
      hold_mem[h_wa] <= h_wd;
    end
    if (h_re) begin
      h_q_r <= hold_mem[h_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (i_we) begin
      inp_mem[i_wa] <= i_wd;
    end
    if (ctl.map_rd) begin
      i_q_r <= inp_mem[msum[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (is_rx && (frame_len_r < LW'(FRAME_DEPTH))) begin
      frame_mem[frame_len_r[FAW-1:0]] <= in_data.rx_byte;
    end
    if (fr_re) begin
      fr_q_r <= frame_mem[fidx[FAW-1:0]];
    end
  end

  // response byte mux
  assign word_v = map_ok_r ? (hsel_r ? h_q_r : i_q_r) : 16'h0000;
  assign val_v  = (fk_r == FK_MULTI) ? 16'(q_r) : raw_r;

  always_comb begin
    case (ctl.sel)
      SEL_ID:   tx_b = slave_id_r;
      SEL_FUNC: tx_b = (fk_r == FK_OTHER) ? (func_r + F_EXC_FLAG) : func_r;
      SEL_CNT:  tx_b = 8'({q_r, 1'b0});
      SEL_WHI:  tx_b = word_v[15:8];
      SEL_WLO:  tx_b = word_v[7:0];
      SEL_AHI:  tx_b = addr_r[15:8];
      SEL_ALO:  tx_b = addr_r[7:0];
      SEL_VHI:  tx_b = val_v[15:8];
      SEL_VLO:  tx_b = val_v[7:0];
      SEL_CLO:  tx_b = rcrc_r[7:0];
      SEL_CHI:  tx_b = rcrc_r[15:8];
      default:  tx_b = 8'h00;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_id_r  <= 8'd1;
      frame_len_r <= '0;
      crc_r       <= 16'hFFFF;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
    end else begin
      if (cfg_we) begin
        slave_id_r <= cfg_wdata;
      end
      if (ctl.clr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (is_rx) begin
        if (frame_len_r < LW'(FRAME_DEPTH)) begin
          frame_len_r <= frame_len_r + LW'(1);
        end else begin
          frame_len_r <= LW'(FRAME_DEPTH + 1);
        end
        crc_r <= crc_fold(crc_r, in_data.rx_byte);
      end else if (ctl.judge) begin
        frame_len_r <= '0;
        crc_r       <= 16'hFFFF;
      end
      if (ctl.judge || ctl.i_clr) begin
        i_r <= '0;
      end else if (ctl.i_inc) begin
        i_r <= i_r + QW'(1);
      end
      if (ctl.emit || ctl.lrd_out || is_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_rx && (frame_len_r < LW'(6))) begin
      hdr_r[frame_len_r[2:0]] <= in_data.rx_byte;
    end
    if (ctl.judge) begin
      func_r     <= func_c;
      fk_r       <= fk_c;
      addr_r     <= addr_c;
      raw_r      <= raw_c;
      q_r        <= q_c;
      resp_len_r <= frame_len_r;
      rcrc_r     <= 16'hFFFF;
    end else if (ctl.emit && (ctl.sel != SEL_CLO) && (ctl.sel != SEL_CHI)) begin
      rcrc_r <= crc_fold(rcrc_r, tx_b);
    end
    if (ctl.map_rd) begin
      map_ok_r <= m_in;
      hsel_r   <= (func_r == F_RD_HOLD);
    end else if (is_read) begin
      map_ok_r <= ra_in;
    end
    if (fr_re) begin
      fr_ok_r <= fr_in;
    end
    if (ctl.fr_rd_lo) begin
      hi_r <= fr_ok_r ? fr_q_r : 8'h00;
    end
    if (ctl.emit) begin
      out_r <= '{kind: KIND_RESP, tx_byte: tx_b, tx_last: (ctl.sel == SEL_CHI),
                 read_value: 16'h0000};
    end else if (ctl.lrd_out) begin
      out_r <= '{kind: KIND_LOCAL, tx_byte: 8'h00, tx_last: 1'b0,
                 read_value: map_ok_r ? h_q_r : 16'h0000};
    end else if (is_load) begin
      out_r <= '{kind: KIND_LOCAL, tx_byte: 8'h00, tx_last: 1'b0, read_value: 16'h0000};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.clr_done = (clr_cnt_r == AW'(MAP_DEPTH - 1));
  assign sts.out_free = out_free;
  assign sts.good     = good_c;
  assign sts.fk       = ctl.judge ? fk_c : fk_r;
  assign sts.q_zero   = ctl.judge ? (q_c == '0) : (q_r == '0);
  assign sts.i_last   = (i_r + QW'(1)) == q_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit || ctl.lrd_out || is_load) |-> out_free)
    else $error("output word overwritten");
  a_judge_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.judge |=> (frame_len_r == '0) && (crc_r == 16'hFFFF))
    else $error("frame state not cleared");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frame_len_r <= LW'(FRAME_DEPTH + 1))
    else $error("frame length out of range");

endmodule

/* sv/mrs_ctrl.sv */
// controller: sequences clearing, local access, frame judging, write-multiple word writes and response bytes
module mrs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mrs_pkg::in_word_t in_data,
  input  mrs_pkg::sts_t     sts,
  output mrs_pkg::ctl_t     ctl
);
  import mrs_pkg::*;

  localparam logic [4:0] ST_CLEAR = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_LRD   = 5'd2;
  localparam logic [4:0] ST_JUDGE = 5'd3;
  localparam logic [4:0] ST_W0    = 5'd4;
  localparam logic [4:0] ST_W1    = 5'd5;
  localparam logic [4:0] ST_W2    = 5'd6;
  localparam logic [4:0] ST_ID    = 5'd7;
  localparam logic [4:0] ST_FUNC  = 5'd8;
  localparam logic [4:0] ST_CNT   = 5'd9;
  localparam logic [4:0] ST_RA    = 5'd10;
  localparam logic [4:0] ST_WHI   = 5'd11;
  localparam logic [4:0] ST_WLO   = 5'd12;
  localparam logic [4:0] ST_AHI   = 5'd13;
  localparam logic [4:0] ST_ALO   = 5'd14;
  localparam logic [4:0] ST_VHI   = 5'd15;
  localparam logic [4:0] ST_VLO   = 5'd16;
  localparam logic [4:0] ST_CLO   = 5'd17;
  localparam logic [4:0] ST_CHI   = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic       acc;

  assign in_ready = (state_r == ST_IDLE) && sts.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.sel   = SEL_ID;
    case (state_r)
      ST_CLEAR: begin
        ctl.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ctl.take = acc;
        if (acc && (in_data.command == CMD_READ)) begin
          state_nxt = ST_LRD;
        end else if (acc && (in_data.command == CMD_RX) && in_data.frame_end) begin
          state_nxt = ST_JUDGE;
        end
      end
      ST_LRD: begin
        ctl.lrd_out = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_JUDGE: begin
        ctl.judge = 1'b1;
        if (!sts.good) begin
          state_nxt = ST_IDLE;
        end else if ((sts.fk == FK_MULTI) && !sts.q_zero) begin
          state_nxt = ST_W0;
        end else begin
          state_nxt = ST_ID;
        end
      end
      ST_W0: begin
        ctl.fr_rd_hi = 1'b1;
        state_nxt    = ST_W1;
      end
      ST_W1: begin
        ctl.fr_rd_lo = 1'b1;
        state_nxt    = ST_W2;
      end
      ST_W2: begin
        ctl.wr_word = 1'b1;
        if (sts.i_last) begin
          ctl.i_clr = 1'b1;
          state_nxt = ST_ID;
        end else begin
          ctl.i_inc = 1'b1;
          state_nxt = ST_W0;
        end
      end
      ST_ID: begin
        ctl.sel = SEL_ID;
        if (sts.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = ST_FUNC;
        end
      end
      ST_FUNC: begin
        ctl.sel = SEL_FUNC;
        if (sts.out_free) begin
          ctl.emit = 1'b1;
          if (sts.fk == FK_READ) begin
            state_nxt = ST_CNT;
          end else if ((sts.fk == FK_ECHO) || (sts.fk == FK_MULTI)) begin
            state_nxt = ST_AHI;
          end else begin
            state_nxt = ST_CLO;
          end
        end
      end
      ST_CNT: begin
        ctl.sel = SEL_CNT;
        if (sts.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = sts.q_zero ? ST_CLO : ST_RA;
        end
      end
      ST_RA: begin
        ctl.map_rd = 1'b1;
        state_nxt  = ST_WHI;
      end
      ST_WHI: begin
        ctl.sel = SEL_WHI;
        if (sts.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = ST_WLO;
        end
      end
      ST_WLO: begin
        ctl.sel = SEL_WLO;
        if (sts.out_free) begin
          ctl.emit = 1'b1;
          if (sts.i_last) begin
            ctl.i_clr = 1'b1;
            state_nxt = ST_CLO;
          end else begin
            ctl.i_inc = 1'b1;
            state_nxt = ST_RA;
          end
        end
      end
      ST_AHI, ST_ALO, ST_VHI, ST_VLO, ST_CLO, ST_CHI: begin
        case (state_r)
          ST_AHI:  ctl.sel = SEL_AHI;
          ST_ALO:  ctl.sel = SEL_ALO;
          ST_VHI:  ctl.sel = SEL_VHI;
          ST_VLO:  ctl.sel = SEL_VLO;
          ST_CLO:  ctl.sel = SEL_CLO;
          default: ctl.sel = SEL_CHI;
        endcase
        if (sts.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = (state_r == ST_CHI) ? ST_IDLE : state_r + 5'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/modbus_rtu_slave_register_server.sv */
// top level of the modbus rtu slave register server
// After reset the block clears both register maps, one entry per cycle, and accepts no
// word until that is done (slave_id writes are taken throughout). Input is accepted only
// in the idle state while the output register is empty or being read out; a local holding
// read then passes through a read-out state. A judge state checks each ended frame and
// drops a bad one; then the response is built one byte per cycle while the output register
// is free, with a map read before each returned register word, and a write-multiple first
// passes each data word through states W0, W1 and W2 on the single frame store port.
module modbus_rtu_slave_register_server #(
  parameter int MAP_DEPTH      = mrs_pkg::MAP_DEPTH_DEF,
  parameter int FRAME_DEPTH    = mrs_pkg::FRAME_DEPTH_DEF,
  parameter int MAX_READ_WORDS = mrs_pkg::MAX_READ_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mrs_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mrs_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import mrs_pkg::*;

  ctl_t ctl;
  sts_t sts;

  mrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .sts      (sts),
    .ctl      (ctl)
  );

  mrs_dp #(
    .MAP_DEPTH      (MAP_DEPTH),
    .FRAME_DEPTH    (FRAME_DEPTH),
    .MAX_READ_WORDS (MAX_READ_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* verif/tb_top.sv */
// testbench for the modbus rtu slave register server: frames, local ports, station address
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mrs_pkg::*;

  localparam int MAPD = 256;
  localparam int FRD = 256;
  localparam int QMAX = 17;
  localparam int IDLE_LIMIT = 20000;

  class modbus_scoreboard;
    logic [7:0] frame_bytes[FRD];
    int unsigned frame_len;
    logic [15:0] crc_acc;
    logic [15:0] hold_map[MAPD];
    logic [15:0] input_map[MAPD];
    logic [7:0] station;
    out_word_t pending_words[$];
    int errors;

    function void clear_state();
      frame_len = 0;
      crc_acc = 16'hFFFF;
      foreach (hold_map[i]) hold_map[i] = '0;
      foreach (input_map[i]) input_map[i] = '0;
      station = 8'd1;
      errors = 0;
    endfunction

    function logic [7:0] byte_at(int unsigned i);
      if (i < frame_len && i < FRD) return frame_bytes[i];
      return 8'h00;
    endfunction

    function logic [15:0] word_at(int unsigned i);
      return {byte_at(i), byte_at(i + 1)};
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int n = 0; n < 8; n++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
    endfunction

    function void push_word(logic kind, logic [7:0] b, logic last, logic [15:0] v);
      out_word_t w;
      w.kind = kind;
      w.tx_byte = b;
      w.tx_last = last;
      w.read_value = v;
      pending_words.push_back(w);
    endfunction

    function void answer_frame();
      logic [7:0] resp[$];
      logic [7:0] func;
      int unsigned addr, q;
      logic [15:0] raw, w, c;
      if (frame_len < 4 || frame_len > FRD || crc_acc != 16'h0) return;
      if (byte_at(0) != station) return;
      func = byte_at(1);
      addr = word_at(2);
      raw = word_at(4);
      q = raw < QMAX ? raw : QMAX;
      resp.push_back(station);
      resp.push_back(func);
      case (func)
        F_RD_COILS, F_RD_DISC, F_WR_COIL: ;
        F_RD_HOLD, F_RD_INPUT: begin
          resp.push_back(8'(q * 2));
          for (int unsigned i = 0; i < q; i++) begin
            w = '0;
            if (addr + i < MAPD)
              w = (func == F_RD_HOLD) ? hold_map[addr + i] : input_map[addr + i];
            resp.push_back(w[15:8]);
            resp.push_back(w[7:0]);
          end
        end
        F_WR_REG: begin
          if (addr < MAPD) hold_map[addr] = raw;
          resp.push_back(8'(addr >> 8));
          resp.push_back(8'(addr));
          resp.push_back(raw[15:8]);
          resp.push_back(raw[7:0]);
        end
        F_WR_MULTI: begin
          for (int unsigned i = 0; i < q; i++)
            if (addr + i < MAPD) hold_map[addr + i] = word_at(7 + 2 * i);
          resp.push_back(8'(addr >> 8));
          resp.push_back(8'(addr));
          resp.push_back(8'(q >> 8));
          resp.push_back(8'(q));
        end
        default: resp[1] = func + F_EXC_FLAG;
      endcase
      c = 16'hFFFF;
      foreach (resp[k]) c = crc_step(c, resp[k]);
      resp.push_back(c[7:0]);
      resp.push_back(c[15:8]);
      foreach (resp[k]) push_word(KIND_RESP, resp[k], k == resp.size() - 1, 16'h0);
    endfunction

    function void note_input(in_word_t d);
      if (d.command == CMD_LOAD) begin
        if (d.reg_address < MAPD) input_map[d.reg_address] = d.reg_value;
        push_word(KIND_LOCAL, 8'h0, 1'b0, 16'h0);
      end else if (d.command == CMD_READ) begin
        push_word(KIND_LOCAL, 8'h0, 1'b0,
                  d.reg_address < MAPD ? hold_map[d.reg_address] : 16'h0);
      end else if (d.command == CMD_RX) begin
        if (frame_len < FRD) begin
          frame_bytes[frame_len] = d.rx_byte;
          frame_len++;
        end else frame_len = FRD + 1;
        crc_acc = crc_step(crc_acc, d.rx_byte);
        if (d.frame_end) begin
          answer_frame();
          frame_len = 0;
          crc_acc = 16'hFFFF;
        end
      end
    endfunction

    function void check_output(out_word_t got);
      out_word_t exp_w;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.kind !== exp_w.kind || got.tx_byte !== exp_w.tx_byte ||
          got.tx_last !== exp_w.tx_last || got.read_value !== exp_w.read_value) begin
        $display({"%0t: mismatch, expected kind %0d byte %h last %0d value %h,",
                  " actual kind %0d byte %h last %0d value %h"},
                 $realtime, exp_w.kind, exp_w.tx_byte, exp_w.tx_last, exp_w.read_value,
                 got.kind, got.tx_byte, got.tx_last, got.read_value);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_we;
  in_word_t in_data;
  out_word_t out_data;
  logic [7:0] cfg_wdata;

  modbus_scoreboard sb;
  int idle_cycles;
  int in_idle_pct, out_idle_pct;
  bit out_hold;
  logic [7:0] cur_station;
  logic [7:0] cfg_wdata_vals[4] = '{8'd0, 8'd255, 8'hA5, 8'd1};

  modbus_rtu_slave_register_server dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_output(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !out_hold && ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("modbus_rtu_slave_register_server verification failed");
      $finish;
    end
  end

  // valid stays up after the accept until the next word or an explicit stop
  task automatic send_word(in_word_t d);
    while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_rx(logic [7:0] b, logic last);
    in_word_t d;
    d.command = CMD_RX;
    d.rx_byte = b;
    d.frame_end = last;
    d.reg_address = 16'($urandom);
    d.reg_value = 16'($urandom);
    send_word(d);
  endtask

  task automatic send_local(logic [1:0] cmd, logic [15:0] a, logic [15:0] v);
    in_word_t d;
    d.command = cmd;
    d.rx_byte = 8'($urandom);
    d.frame_end = 1'($urandom);
    d.reg_address = a;
    d.reg_value = v;
    send_word(d);
  endtask

  // sends bytes, optionally with a correct crc appended, last byte marked
  task automatic send_frame(logic [7:0] body[$], bit good_crc);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (body[k]) c = sb.crc_step(c, body[k]);
    if (good_crc) begin
      body.push_back(c[7:0]);
      body.push_back(c[15:8]);
    end
    foreach (body[k]) send_rx(body[k], k == body.size() - 1);
  endtask

  task automatic send_request(logic [7:0] id, logic [7:0] func, logic [15:0] addr,
                              logic [15:0] qv, int nwords);
    logic [7:0] body[$];
    body = {id, func, addr[15:8], addr[7:0], qv[15:8], qv[7:0]};
    if (func == F_WR_MULTI) begin
      body.push_back(8'(nwords * 2));
      for (int i = 0; i < nwords; i++) begin
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
      end
    end
    send_frame(body, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_station(logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.station = v;
    cur_station = v;
  endtask

  function automatic logic [15:0] rand_addr();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'(MAPD - 1 - $urandom_range(3));
      default: return 16'($urandom_range(40));
    endcase
  endfunction

  task automatic random_item();
    logic [7:0] func;
    logic [7:0] body[$];
    logic [7:0] funcs[8];
    int n;
    funcs = '{F_RD_COILS, F_RD_DISC, F_RD_HOLD, F_RD_INPUT, F_WR_COIL, F_WR_REG, F_WR_MULTI,
              8'h2B};
    case ($urandom_range(9))
      0: send_local(CMD_LOAD, rand_addr(), 16'($urandom));
      1: send_local(CMD_READ, rand_addr(), 16'($urandom));
      2: begin
        n = $urandom_range(1, 9);
        for (int i = 0; i < n; i++) body.push_back(8'($urandom));
        send_frame(body, 1'($urandom_range(1)));
      end
      3: send_local(2'd3, 16'($urandom), 16'($urandom));
      default: begin
        func = funcs[$urandom_range(7)];
        if ($urandom_range(9) == 0) func = 8'($urandom);
        n = $urandom_range(0, 6);
        send_request(($urandom_range(7) == 0) ? 8'($urandom) : cur_station, func, rand_addr(),
                     ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)), n);
      end
    endcase
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    out_hold = 1'b0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    cur_station = 8'd1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_local(CMD_LOAD, 16'd0, 16'hFFFF);
    send_local(CMD_LOAD, 16'd255, 16'h8001);
    send_local(CMD_LOAD, 16'hFFFF, 16'h1234);
    send_request(8'd1, F_WR_REG, 16'd255, 16'hFFFF, 0);
    send_request(8'd1, F_WR_REG, 16'd300, 16'h5555, 0);
    send_request(8'd1, F_WR_MULTI, 16'd250, 16'd8, 8);
    send_request(8'd1, F_RD_HOLD, 16'd250, 16'hFFFF, 0);
    send_request(8'd1, F_RD_INPUT, 16'd0, 16'd0, 0);
    send_request(8'd1, F_RD_INPUT, 16'd254, 16'd3, 0);
    send_local(CMD_READ, 16'd255, 16'h0);
    send_local(CMD_READ, 16'hFFFF, 16'h0);
    send_request(8'd1, F_RD_COILS, 16'd0, 16'd0, 0);
    send_request(8'd1, F_WR_COIL, 16'd0, 16'd0, 0);
    send_request(8'd1, 8'hFF, 16'd0, 16'd0, 0);
    send_request(8'd2, F_RD_HOLD, 16'd0, 16'd1, 0);
    send_frame({8'h01, 8'h03, 8'h00}, 1'b0);
    send_frame({8'h01, 8'h03}, 1'b1);
    send_request(8'd1, F_WR_MULTI, 16'd10, 16'd4, 1);
    send_local(2'd3, 16'h0, 16'h0);
    drain();

    // receiver holds off long while the sender keeps offering
    out_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        out_hold = 1'b0;
      end
      begin
        for (int i = 0; i < 3; i++) send_request(cur_station, F_RD_HOLD, 16'd0, 16'd17, 0);
        in_valid <= 1'b0;
      end
    join
    drain();

    foreach (cfg_wdata_vals[i]) begin
      set_station(cfg_wdata_vals[i]);
      in_idle_pct = (i == 1) ? 0 : 10;
      out_idle_pct = (i == 1) ? 0 : 10;
      for (int k = 0; k < 14; k++) random_item();
      drain();
    end
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("modbus_rtu_slave_register_server verification clean");
    end else begin
      $display("modbus_rtu_slave_register_server verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/mrs_pkg.sv
sv/mrs_dp.sv
sv/mrs_ctrl.sv
sv/modbus_rtu_slave_register_server.sv
verif/tb_top.sv
